// ===== rtl/core/dmsc_pkg.sv =====
// Shared types, constants and the natural-log table for the density map support compare.
`timescale 1ns / 1ps

package dmsc_pkg;

  localparam int COUNT_BITS = 8;
  localparam int FRAME_WIDTH = 1920;
  localparam int FRAME_HEIGHT = 1080;
  localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int IN_CNT_W = 8;
  localparam int FRAME_W = 32;
  localparam int CNT_W = 21;
  localparam int SUM_W = 40;
  localparam int LN_W = 20;
  localparam int LN_DEPTH = 2 ** COUNT_BITS;

  localparam logic [IN_CNT_W-1:0] CNT_SAT = IN_CNT_W'(LN_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [63:0] LN2_Q032 = 64'd2977044472;

  typedef struct packed {
    logic [IN_CNT_W-1:0] ref_count;
    logic [IN_CNT_W-1:0] sys_count;
    logic [FRAME_W-1:0]  frame_id;
    logic                last_pixel;
  } in_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic [CNT_W-1:0]   neither_count;
    logic [CNT_W-1:0]   both_count;
    logic [CNT_W-1:0]   ref_only_count;
    logic [CNT_W-1:0]   sys_only_count;
    logic [SUM_W-1:0]   log_ratio_sum;
  } out_res_t;

  typedef enum logic [1:0] {
    CLS_NEITHER,
    CLS_SYS_ONLY,
    CLS_REF_ONLY,
    CLS_BOTH
  } pix_class_t;

  typedef struct packed {
    pix_class_t         cls;
    logic [LN_W-1:0]    diff;
    logic [FRAME_W-1:0] frame;
    logic               last;
  } pix_info_t;

  typedef logic [LN_W-1:0] ln_rom_t [LN_DEPTH];

  // ln(n) in Q4.16: log2 by repeated squaring of the normalized mantissa,
  // scaled by ln 2 and rounded half up. Entry zero is never used.
  function automatic ln_rom_t build_ln_rom();
    ln_rom_t     rom;
    logic [63:0] m;
    logic [63:0] l2;
    logic [63:0] p;
    int          n;
    int          j;
    int          i;
    int          k;
    rom[0] = '0;
    for (n = 1; n < LN_DEPTH; n++) begin
      k = 0;
      for (j = 0; j < COUNT_BITS; j++) begin
        if (((n >> j) & 1) != 0) begin
          k = j;
        end
      end
      m = 64'(n) << (31 - k);
      l2 = 64'(k);
      for (i = 0; i < 28; i++) begin
        m = (m * m) >> 31;
        l2 = l2 << 1;
        if (m >= 64'h1_0000_0000) begin
          l2 = l2 | 64'd1;
          m = m >> 1;
        end
      end
      p = l2 * LN2_Q032;
      rom[n] = LN_W'((p + (64'd1 << 43)) >> 44);
    end
    return rom;
  endfunction

  localparam ln_rom_t LN_ROM = build_ln_rom();

endpackage

// ===== rtl/core/dmsc_classify.sv =====
// Pixel classifier: saturates both counts, sorts the pixel and forms the absolute log ratio.
`timescale 1ns / 1ps

module dmsc_classify (
  input  dmsc_pkg::in_req_t   px,
  output dmsc_pkg::pix_info_t info
);
  import dmsc_pkg::*;

  logic [COUNT_BITS-1:0] ref_sat;
  logic [COUNT_BITS-1:0] sys_sat;
  logic [LN_W-1:0]       ln_ref;
  logic [LN_W-1:0]       ln_sys;

  always_comb begin
    ref_sat = (px.ref_count > CNT_SAT) ? COUNT_BITS'(CNT_SAT) : COUNT_BITS'(px.ref_count);
    sys_sat = (px.sys_count > CNT_SAT) ? COUNT_BITS'(CNT_SAT) : COUNT_BITS'(px.sys_count);
    ln_ref = LN_ROM[ref_sat];
    ln_sys = LN_ROM[sys_sat];

    info.frame = px.frame_id;
    info.last = px.last_pixel;
    info.diff = '0;
    if (ref_sat == '0 && sys_sat == '0) begin
      info.cls = CLS_NEITHER;
    end else if (ref_sat == '0) begin
      info.cls = CLS_SYS_ONLY;
    end else if (sys_sat == '0) begin
      info.cls = CLS_REF_ONLY;
    end else begin
      info.cls = CLS_BOTH;
      info.diff = (ln_ref > ln_sys) ? (ln_ref - ln_sys) : (ln_sys - ln_ref);
    end
  end

endmodule

// ===== rtl/core/density_map_support_compare.sv =====
// Top level of the density map support compare: pipeline, frame accumulators and result register.
`timescale 1ns / 1ps
// A result is registered once the request carrying the last pixel has passed stage 1 and stage 2.
// Throughput: one pixel request per cycle; the input is held off only when a last pixel
// reaches the accumulators while the previous frame's result is still stalled at the output.
// Reset (rst_n low, synchronous) empties the pipeline, drops any pending result and clears
// all class counters and the log-ratio sum.

module density_map_support_compare (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dmsc_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dmsc_pkg::out_res_t out_data
);
  import dmsc_pkg::*;

  // Stage 1 holds the accepted request; stage 2 holds the classified pixel
  // (class plus |ln ref - ln sys|) that is folded into the accumulators.
  logic      s1_valid_r;
  in_req_t   s1_req_r;
  pix_info_t s1_info;
  logic      s2_valid_r;
  pix_info_t s2_info_r;

  // Per-frame accumulators.
  logic [CNT_W-1:0] neither_acc_r, neither_acc_nxt;
  logic [CNT_W-1:0] both_acc_r, both_acc_nxt;
  logic [CNT_W-1:0] ref_only_acc_r, ref_only_acc_nxt;
  logic [CNT_W-1:0] sys_only_acc_r, sys_only_acc_nxt;
  logic [SUM_W-1:0] log_acc_r, log_acc_nxt;
  logic [SUM_W:0]   log_sum;

  logic     out_valid_r;
  out_res_t out_res_r;

  logic out_free;
  logic s2_consume;
  logic s2_ready;
  logic s1_ready;
  logic out_load;

  dmsc_classify u_classify (
    .px   (s1_req_r),
    .info (s1_info)
  );

  // A non-last pixel never needs the output register, so it drains into the
  // accumulators even while a finished result waits to be taken.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s2_consume = s2_valid_r && (!s2_info_r.last || out_free);
    s2_ready = !s2_valid_r || s2_consume;
    s1_ready = !s1_valid_r || s2_ready;
    out_load = s2_consume && s2_info_r.last;
  end

  assign in_stall = !s1_ready;

  // Saturating accumulate for the pixel in stage 2.
  always_comb begin
    neither_acc_nxt = neither_acc_r;
    both_acc_nxt = both_acc_r;
    ref_only_acc_nxt = ref_only_acc_r;
    sys_only_acc_nxt = sys_only_acc_r;
    log_sum = {1'b0, log_acc_r} + (SUM_W + 1)'(s2_info_r.diff);
    log_acc_nxt = log_acc_r;
    case (s2_info_r.cls)
      CLS_NEITHER: begin
        if (neither_acc_r != CNT_MAX) neither_acc_nxt = neither_acc_r + 1'b1;
      end
      CLS_SYS_ONLY: begin
        if (sys_only_acc_r != CNT_MAX) sys_only_acc_nxt = sys_only_acc_r + 1'b1;
      end
      CLS_REF_ONLY: begin
        if (ref_only_acc_r != CNT_MAX) ref_only_acc_nxt = ref_only_acc_r + 1'b1;
      end
      default: begin
        if (both_acc_r != CNT_MAX) both_acc_nxt = both_acc_r + 1'b1;
        log_acc_nxt = log_sum[SUM_W] ? SUM_MAX : log_sum[SUM_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      neither_acc_r <= '0;
      both_acc_r <= '0;
      ref_only_acc_r <= '0;
      sys_only_acc_r <= '0;
      log_acc_r <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      // The last pixel is counted into the result, then the frame starts over.
      if (s2_consume) begin
        if (s2_info_r.last) begin
          neither_acc_r <= '0;
          both_acc_r <= '0;
          ref_only_acc_r <= '0;
          sys_only_acc_r <= '0;
          log_acc_r <= '0;
        end else begin
          neither_acc_r <= neither_acc_nxt;
          both_acc_r <= both_acc_nxt;
          ref_only_acc_r <= ref_only_acc_nxt;
          sys_only_acc_r <= sys_only_acc_nxt;
          log_acc_r <= log_acc_nxt;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_req_r <= in_data;
    end
    if (s2_ready && s1_valid_r) begin
      s2_info_r <= s1_info;
    end
    if (out_load) begin
      out_res_r.frame_out <= s2_info_r.frame;
      out_res_r.neither_count <= neither_acc_nxt;
      out_res_r.both_count <= both_acc_nxt;
      out_res_r.ref_only_count <= ref_only_acc_nxt;
      out_res_r.sys_only_count <= sys_only_acc_nxt;
      out_res_r.log_ratio_sum <= log_acc_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_res_r;

  // Emitting a result must leave every accumulator cleared.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (neither_acc_r == '0 && both_acc_r == '0 && ref_only_acc_r == '0 &&
                  sys_only_acc_r == '0 && log_acc_r == '0))
    else $error("accumulators not cleared after a result was emitted");

  // The input is only held off when both pipeline stages are occupied and stage 2 holds a last pixel.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && s2_info_r.last))
    else $error("input stalled with room in the pipeline");

  // The log-ratio sum only grows with pixels present in both maps.
  a_log_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
    (both_acc_r == '0) |-> (log_acc_r == '0))
    else $error("log-ratio sum nonzero with no pixel present in both maps");

  // Only pixels present in both maps carry a log ratio.
  a_diff_only_both: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_info_r.cls != CLS_BOTH) |-> (s2_info_r.diff == '0))
    else $error("log ratio on a pixel not present in both maps");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for density_map_support_compare: pixel stream and frame result checks.
`timescale 1ns / 1ps

module testbench;
  import dmsc_pkg::*;

  // The bench stops if no request moves on either channel for this many cycles.
  // A correct run stays well under this limit, since the random waits on each
  // side are bounded.
  localparam int IDLE_LIMIT = 2000;
  // This is a generous margin for catching stray results after the final expected one.
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_PIXELS = 900;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;

  density_map_support_compare u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pixel requests waiting to be driven, and the frame results that the
  // accepted pixels have produced but the block has not yet delivered.
  in_req_t  pixel_q[$];
  out_res_t frame_result_q[$];

  // Running frame tallies, kept the same way the block keeps its own.
  logic [CNT_W-1:0] tally_neither = '0;
  logic [CNT_W-1:0] tally_both = '0;
  logic [CNT_W-1:0] tally_ref_only = '0;
  logic [CNT_W-1:0] tally_sys_only = '0;
  logic [SUM_W-1:0] tally_log = '0;

  int cls_seen[4];
  int pixels_taken = 0;
  int frames_checked = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int sent = 0;
  int out_hold = 0;
  bit in_took = 1'b0;
  bit res_took = 1'b0;

  // ln(n) in unsigned Q4.16. The integer part of log2 is the position of the
  // top set bit. The fraction bits come from squaring the normalized mantissa
  // again and again: each time the square reaches 2.0, the next bit is one.
  // The result is then scaled by ln 2 and rounded half up.
  function automatic logic [LN_W-1:0] ln_fix(input int unsigned n);
    logic [63:0] mant;
    logic [63:0] lg;
    logic [63:0] prod;
    int          msb;
    int          b;
    if (n == 0) return '0;
    msb = 0;
    for (b = 0; b < 32; b++) begin
      if (((n >> b) & 1) != 0) msb = b;
    end
    mant = 64'(n) << (31 - msb);
    lg = 64'(msb);
    for (b = 0; b < 28; b++) begin
      mant = (mant * mant) >> 31;
      lg = lg << 1;
      if (mant >= 64'h1_0000_0000) begin
        lg = lg | 64'd1;
        mant = mant >> 1;
      end
    end
    prod = lg * 64'd2977044472;
    return LN_W'((prod + (64'd1 << 43)) >> 44);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  // Apply one accepted pixel to the tallies. On a pixel marked last, queue
  // the frame result and clear the tallies for the next frame.
  task automatic tally_pixel(input in_req_t px);
    logic [IN_CNT_W-1:0] r;
    logic [IN_CNT_W-1:0] s;
    logic [LN_W-1:0]     lr;
    logic [LN_W-1:0]     ls;
    logic [SUM_W:0]      sum;
    pix_class_t          pc;
    out_res_t            res;
    r = (px.ref_count > CNT_SAT) ? CNT_SAT : px.ref_count;
    s = (px.sys_count > CNT_SAT) ? CNT_SAT : px.sys_count;
    if (r == 0 && s == 0) pc = CLS_NEITHER;
    else if (r == 0) pc = CLS_SYS_ONLY;
    else if (s == 0) pc = CLS_REF_ONLY;
    else pc = CLS_BOTH;
    cls_seen[pc]++;
    pixels_taken++;
    case (pc)
      CLS_NEITHER:  tally_neither = sat_inc(tally_neither);
      CLS_SYS_ONLY: tally_sys_only = sat_inc(tally_sys_only);
      CLS_REF_ONLY: tally_ref_only = sat_inc(tally_ref_only);
      default: begin
        lr = ln_fix(32'(r));
        ls = ln_fix(32'(s));
        tally_both = sat_inc(tally_both);
        sum = {1'b0, tally_log} + (SUM_W + 1)'((lr > ls) ? lr - ls : ls - lr);
        tally_log = (sum > {1'b0, SUM_MAX}) ? SUM_MAX : sum[SUM_W-1:0];
      end
    endcase
    if (px.last_pixel) begin
      res.frame_out = px.frame_id;
      res.neither_count = tally_neither;
      res.both_count = tally_both;
      res.ref_only_count = tally_ref_only;
      res.sys_only_count = tally_sys_only;
      res.log_ratio_sum = tally_log;
      frame_result_q.insert(frame_result_q.size(), res);
      tally_neither = '0;
      tally_both = '0;
      tally_ref_only = '0;
      tally_sys_only = '0;
      tally_log = '0;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input out_res_t got);
    out_res_t want;
    if (frame_result_q.size() == 0) begin
      note_mismatch("result with no frame pending", 64'(got.frame_out), '0);
      return;
    end
    want = frame_result_q.pop_front();
    frames_checked++;
    if (got.frame_out !== want.frame_out)
      note_mismatch("frame_out", 64'(got.frame_out), 64'(want.frame_out));
    if (got.neither_count !== want.neither_count)
      note_mismatch("neither_count", 64'(got.neither_count), 64'(want.neither_count));
    if (got.both_count !== want.both_count)
      note_mismatch("both_count", 64'(got.both_count), 64'(want.both_count));
    if (got.ref_only_count !== want.ref_only_count)
      note_mismatch("ref_only_count", 64'(got.ref_only_count), 64'(want.ref_only_count));
    if (got.sys_only_count !== want.sys_only_count)
      note_mismatch("sys_only_count", 64'(got.sys_only_count), 64'(want.sys_only_count));
    if (got.log_ratio_sum !== want.log_ratio_sum)
      note_mismatch("log_ratio_sum", 64'(got.log_ratio_sum), 64'(want.log_ratio_sum));
  endtask

  // Monitor. It samples both channels at the rising edge, before the block's
  // registers update. It records which requests moved, so that the falling
  // edge drivers can decide what to present next. It also runs the idle
  // watchdog.
  always @(posedge clk) begin
    in_took = rst_n && in_valid && !in_stall;
    res_took = rst_n && out_valid && !out_stall;
    if (in_took) tally_pixel(in_data);
    if (res_took) check_result(out_data);
    if (in_took || res_took) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles.", IDLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Input driver. A stalled request is held unchanged. After each accepted
  // request it may wait a random gap before presenting the next one.
  // Every third run of 64 requests is sent back to back, with no gaps.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_data <= pixel_q.pop_front();
        in_valid <= 1'b1;
        sent++;
        in_gap = ((sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side. After each delivered result, the stall may be held for a
  // random time. Now and then a stall also starts on its own, with or without
  // a result waiting, so that it may already be up when the next result arrives.
  // Some runs of results are taken with no stall at all.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (((frames_checked / 8) % 3) == 1) begin
        out_hold = 0;
      end else if (res_took || (out_hold == 0 && $urandom_range(0, 11) == 0)) begin
        out_hold = $urandom_range(0, 6);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_pixel(input int unsigned r, input int unsigned s,
                             input logic [FRAME_W-1:0] f, input logic last);
    in_req_t px;
    px.ref_count = IN_CNT_W'(r);
    px.sys_count = IN_CNT_W'(s);
    px.frame_id = f;
    px.last_pixel = last;
    pixel_q.insert(pixel_q.size(), px);
  endtask

  // A density for one map. Nonzero values favor the ends of the range, where
  // the log ratio is largest or zero.
  function automatic int unsigned draw_count(input bit empty);
    int unsigned pick;
    if (empty) return 0;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 1;
    if (pick == 1) return CNT_SAT;
    return $urandom_range(1, CNT_SAT);
  endfunction

  initial begin
    int          queued;
    int          len;
    int          p;
    int unsigned lim;
    logic [31:0] fr;
    pix_class_t  pc;

    // Directed part. The very first pixel after reset ends a frame by itself.
    queue_pixel(0, 0, 32'h0000_0000, 1'b1);
    // A one-pixel frame where both densities are at full scale and equal.
    queue_pixel(CNT_SAT, CNT_SAT, 32'hFFFF_FFFF, 1'b1);
    // One pixel of every class, with the largest log ratio in both
    // directions and a zero ratio. The frame number changes on the last
    // pixel, and the result must carry the last pixel's frame number.
    queue_pixel(0, 0, 32'h5555_AAAA, 1'b0);
    queue_pixel(5, 0, 32'h5555_AAAA, 1'b0);
    queue_pixel(0, 7, 32'h5555_AAAA, 1'b0);
    queue_pixel(CNT_SAT, 1, 32'h5555_AAAA, 1'b0);
    queue_pixel(1, CNT_SAT, 32'h5555_AAAA, 1'b0);
    queue_pixel(128, 128, 32'h5555_AAAA, 1'b0);
    queue_pixel(1, 1, 32'h5555_AAAA, 1'b0);
    queue_pixel(CNT_SAT, CNT_SAT - 1, 32'hAAAA_5555, 1'b1);
    // Single-pixel frames: one system only, one reference only and two in both maps.
    queue_pixel(0, CNT_SAT, 32'h8000_0001, 1'b1);
    queue_pixel(CNT_SAT, 0, 32'h7FFF_FFFE, 1'b1);
    queue_pixel(1, CNT_SAT, 32'h0000_0001, 1'b1);
    queue_pixel(2, 3, 32'hFFFF_FFFE, 1'b1);
    queued = pixel_q.size();

    // Random frames. Most are short, so many results come back; a few run to
    // a few hundred pixels. Some pixels carry a stray frame number, which the
    // block must ignore unless that pixel is the last one.
    while (queued < RANDOM_PIXELS + 14) begin
      lim = $urandom_range(0, 19);
      if (lim == 0) len = $urandom_range(100, 300);
      else if (lim < 4) len = $urandom_range(20, 99);
      else len = $urandom_range(1, 19);
      fr = $urandom();
      for (p = 0; p < len; p++) begin
        pc = pix_class_t'($urandom_range(0, 3));
        queue_pixel(draw_count(pc == CLS_NEITHER || pc == CLS_SYS_ONLY),
                    draw_count(pc == CLS_NEITHER || pc == CLS_REF_ONLY),
                    ($urandom_range(0, 9) == 0) ? $urandom() : fr,
                    p == len - 1);
      end
      queued += len;
    end

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every pixel has been accepted and every frame result has
    // come back. Then let the pipeline drain, to catch any extra result.
    while (pixel_q.size() != 0 || in_valid) @(posedge clk);
    while (frame_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (frame_result_q.size() != 0)
      note_mismatch("frame results never delivered", 64'(frame_result_q.size()), '0);
    $display("Run covered %0d pixel requests in %0d checked frame results.",
             pixels_taken, frames_checked);
    $display("Pixel classes: %0d empty, %0d both, %0d reference only, %0d system only.",
             cls_seen[CLS_NEITHER], cls_seen[CLS_BOTH], cls_seen[CLS_REF_ONLY],
             cls_seen[CLS_SYS_ONLY]);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
